@@ rtl/core/cfp_pkg.sv @@
`default_nettype none
package cfp_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned VALUE_WIDTH     = 32;
    localparam int unsigned FRAC_WIDTH      = 16;
    localparam int unsigned APB_ADDR_WIDTH  = 3;
    localparam int unsigned APB_DATA_WIDTH  = 32;
    localparam int unsigned OUTQ_DEPTH      = 8;
    localparam logic [FRAC_WIDTH-1:0] FUZZ_RESET = 16'd6554;

    // word index of each configuration register (paddr[2])
    localparam logic REG_FUZZ = 1'b0;

    typedef struct packed {
        logic                   vld;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic [VALUE_WIDTH-1:0] delta;
    } t_fuzz_item;

endpackage
`default_nettype wire

@@ rtl/core/cfp_regs.sv @@
`default_nettype none
module cfp_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [cfp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [cfp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [cfp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic      [cfp_pkg::FRAC_WIDTH-1:0]       o_fuzz
);

    logic [cfp_pkg::FRAC_WIDTH-1:0] r_fuzz;
    logic                           wr_fuzz;

    assign wr_fuzz = psel && penable && pwrite && (paddr[2] == cfp_pkg::REG_FUZZ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fuzz <= cfp_pkg::FUZZ_RESET;
        end else if (wr_fuzz) begin
            r_fuzz <= pwdata[cfp_pkg::FRAC_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == cfp_pkg::REG_FUZZ) begin
            prdata = {{(cfp_pkg::APB_DATA_WIDTH-cfp_pkg::FRAC_WIDTH){1'b0}}, r_fuzz};
        end
    end

    assign o_fuzz = r_fuzz;

endmodule
`default_nettype wire

@@ rtl/core/cfp_fuzz.sv @@
`default_nettype none
// Input register, then the half-width multiply into a second register.
module cfp_fuzz (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [cfp_pkg::VALUE_WIDTH-1:0]   i_value,
    input  wire logic                              i_last,
    input  wire logic [cfp_pkg::FRAC_WIDTH-1:0]    i_fuzz,
    output cfp_pkg::t_fuzz_item                    o_item,
    output logic      [1:0]                        o_occ
);

    localparam int unsigned PW = cfp_pkg::VALUE_WIDTH + cfp_pkg::FRAC_WIDTH;

    logic                            r_a_vld;
    logic [cfp_pkg::VALUE_WIDTH-1:0] r_a_value;
    logic                            r_a_last;
    cfp_pkg::t_fuzz_item             r_b;
    logic [PW-1:0]                   prod;

    // product is exact; drop the 16 fraction bits
    assign prod = {{cfp_pkg::FRAC_WIDTH{1'b0}}, r_a_value}
                * {{cfp_pkg::VALUE_WIDTH{1'b0}}, i_fuzz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b.vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
            r_b.vld <= r_a_vld;
        end
        if (i_accept) begin
            r_a_value <= i_value;
            r_a_last  <= i_last;
        end
        r_b.value <= r_a_value;
        r_b.last  <= r_a_last;
        r_b.delta <= prod[PW-1:cfp_pkg::FRAC_WIDTH];
    end

    assign o_item = r_b;
    assign o_occ  = {1'b0, r_a_vld} + {1'b0, r_b.vld};

endmodule
`default_nettype wire

@@ rtl/core/cfp_track.sv @@
`default_nettype none
// Cluster merge and peak tracking; emits up to two results per value.
module cfp_track #(
    parameter int unsigned COUNT_WIDTH = cfp_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned RES_WIDTH   = 132 + 3 * COUNT_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  cfp_pkg::t_fuzz_item        i_item,
    output logic                       o_a_vld,
    output logic [RES_WIDTH-1:0]       o_a_data,
    output logic                       o_b_vld,
    output logic [RES_WIDTH-1:0]       o_b_data
);

    localparam int unsigned VW = cfp_pkg::VALUE_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] ties;
        logic [VW-1:0]          low;
        logic [VW:0]            high;
    } t_peak;

    function automatic t_peak peak_fold(input t_peak best, input logic [COUNT_WIDTH-1:0] cnt,
                                        input logic [VW-1:0] lo, input logic [VW:0] hi);
        t_peak r;
        r = best;
        if (cnt == best.count) begin
            if (best.ties != CMAX) begin
                r.ties = best.ties + 1'b1;
            end
        end else if (cnt > best.count) begin
            r.count = cnt;
            r.ties  = COUNT_WIDTH'(1);
            r.low   = lo;
            r.high  = hi;
        end
        return r;
    endfunction

    logic [VW-1:0]          r_prev, n_prev;
    logic [VW-1:0]          r_low, n_low;
    logic [VW:0]            r_high, n_high;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_open, n_open;
    t_peak                  r_best, n_best;
    logic                   r_fault, n_fault;

    logic                   fault, merge, emit1, emit2;
    logic [VW-1:0]          lo;
    logic [VW:0]            hi;
    t_peak                  peak1, peak2;
    logic [VW-1:0]          c_low;
    logic [VW:0]            c_high;
    logic [COUNT_WIDTH-1:0] c_count;
    t_peak                  c_best;
    logic [RES_WIDTH-1:0]   res1, res2;

    assign fault = r_open && (i_item.value < r_prev);
    assign lo    = i_item.value - i_item.delta;
    assign hi    = {1'b0, i_item.value} + {1'b0, i_item.delta};
    assign merge = r_open && (r_high >= {1'b0, lo});
    assign peak1 = peak_fold(r_best, r_count, r_low, r_high);

    always_comb begin
        n_prev  = r_prev;
        n_low   = r_low;
        n_high  = r_high;
        n_count = r_count;
        n_open  = r_open;
        n_best  = r_best;
        n_fault = r_fault;
        emit1   = 1'b0;
        emit2   = 1'b0;
        if (i_item.vld) begin
            if (fault) begin
                n_fault = 1'b1;
            end else begin
                n_prev = i_item.value;
                if (merge) begin
                    n_high = hi;
                    if (r_count != CMAX) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    emit1 = r_open;
                    if (r_open) begin
                        n_best = peak1;
                    end
                    n_low   = lo;
                    n_high  = hi;
                    n_count = COUNT_WIDTH'(1);
                    n_open  = 1'b1;
                end
            end
        end
        c_low   = n_low;
        c_high  = n_high;
        c_count = n_count;
        c_best  = n_best;
        peak2   = peak_fold(c_best, c_count, c_low, c_high);
        if (i_item.vld && i_item.last) begin
            emit2   = 1'b1;
            n_prev  = '0;
            n_low   = '0;
            n_high  = '0;
            n_count = '0;
            n_open  = 1'b0;
            n_best  = '0;
            n_fault = 1'b0;
        end
    end

    // closed cluster: sticky flag cannot have been raised by this value
    assign res1 = {r_low, r_high, r_count, peak1.count, peak1.ties, peak1.low, peak1.high,
                   r_fault, 1'b0};
    assign res2 = {c_low, c_high, c_count, peak2.count, peak2.ties, peak2.low, peak2.high,
                   r_fault | fault, 1'b1};

    assign o_a_vld  = emit1 | emit2;
    assign o_a_data = emit1 ? res1 : res2;
    assign o_b_vld  = emit1 & emit2;
    assign o_b_data = res2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_low   <= '0;
            r_high  <= '0;
            r_count <= '0;
            r_open  <= 1'b0;
            r_best  <= '0;
            r_fault <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_low   <= n_low;
            r_high  <= n_high;
            r_count <= n_count;
            r_open  <= n_open;
            r_best  <= n_best;
            r_fault <= n_fault;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cfp_outq.sv @@
`default_nettype none
// Result queue taking up to two entries a cycle, one out a cycle.
module cfp_outq #(
    parameter int unsigned WIDTH = 180,
    parameter int unsigned DEPTH = cfp_pkg::OUTQ_DEPTH,
    parameter int unsigned CNTW  = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_a,
    input  wire logic [WIDTH-1:0]  i_data_a,
    input  wire logic              i_push_b,
    input  wire logic [WIDTH-1:0]  i_data_b,
    input  wire logic              i_pop,
    output logic                   o_vld,
    output logic [WIDTH-1:0]       o_head,
    output logic [CNTW-1:0]        o_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             pop;

    assign pop = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr + AW'(i_push_a) + AW'(i_push_b);
        n_rptr  = r_rptr + AW'(pop);
        n_count = r_count + CNTW'(i_push_a) + CNTW'(i_push_b) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[r_wptr + AW'(1)] <= i_data_b;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

@@ rtl/core/fuzzy_cluster_peak_finder_core.sv @@
// A result passes the input register, the multiply register and the result queue before it is valid.
// One input value per cycle while input ready is high; a value that closes a cluster and ends
// the run yields two results, which leave one at a time through an 8-entry result queue.
// Input ready is held low while the queue lacks room for two results per value in flight.
// Synchronous active-low reset clears the run state, the queue and fuzz_fraction (6554).
`default_nettype none
module fuzzy_cluster_peak_finder_core #(
    parameter int unsigned COUNT_WIDTH = cfp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cfp_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [cfp_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [cfp_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                     pready,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [31:0]                         i_sample_value,
    input  wire logic                                i_run_end,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [31:0]                         o_cluster_low,
    output logic      [32:0]                         o_cluster_high,
    output logic      [COUNT_WIDTH-1:0]              o_cluster_members,
    output logic      [COUNT_WIDTH-1:0]              o_peak_members,
    output logic      [COUNT_WIDTH-1:0]              o_peak_ties,
    output logic      [31:0]                         o_peak_low,
    output logic      [32:0]                         o_peak_high,
    output logic                                     o_order_fault,
    output logic                                     o_run_done
);

    localparam int unsigned RES_WIDTH = 132 + 3 * COUNT_WIDTH;
    localparam int unsigned DEPTH     = cfp_pkg::OUTQ_DEPTH;
    localparam int unsigned CNTW      = $clog2(DEPTH + 1);
    localparam int unsigned SW        = CNTW + 3;

    logic [cfp_pkg::FRAC_WIDTH-1:0] fuzz;
    logic                           accept;
    cfp_pkg::t_fuzz_item            item;
    logic [1:0]                     occ;
    logic [2:0]                     need;
    logic                           a_vld, b_vld;
    logic [RES_WIDTH-1:0]           a_data, b_data, head;
    logic [CNTW-1:0]                q_count;

    assign pready = 1'b1;

    cfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_fuzz  (fuzz)
    );

    // each value in flight, and the new one, may need two queue slots
    assign need       = {occ + 2'd1, 1'b0};
    assign o_in_ready = (SW'(q_count) + SW'(need)) <= SW'(DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    cfp_fuzz u_fuzz (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_value  (i_sample_value),
        .i_last   (i_run_end),
        .i_fuzz   (fuzz),
        .o_item   (item),
        .o_occ    (occ)
    );

    cfp_track #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .RES_WIDTH   (RES_WIDTH)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .o_a_vld  (a_vld),
        .o_a_data (a_data),
        .o_b_vld  (b_vld),
        .o_b_data (b_data)
    );

    cfp_outq #(
        .WIDTH (RES_WIDTH),
        .DEPTH (DEPTH),
        .CNTW  (CNTW)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (a_vld),
        .i_data_a (a_data),
        .i_push_b (b_vld),
        .i_data_b (b_data),
        .i_pop    (i_out_ready),
        .o_vld    (o_out_valid),
        .o_head   (head),
        .o_count  (q_count)
    );

    assign {o_cluster_low, o_cluster_high, o_cluster_members, o_peak_members, o_peak_ties,
            o_peak_low, o_peak_high, o_order_fault, o_run_done} = head;

endmodule
`default_nettype wire

@@ test/tb_fuzzy_cluster_peak_finder_core.sv @@
`default_nettype none
module tb_fuzzy_cluster_peak_finder_core;

    localparam int unsigned CW = cfp_pkg::COUNT_WIDTH_DEF;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam int unsigned SETTLE = 8;

    typedef enum logic [1:0] {PACE_RX_HEAVY, PACE_TX_HEAVY, PACE_NONE} t_pace;

    typedef struct packed {
        logic [31:0] value;
        logic        is_last;
    } t_sample;

    typedef struct packed {
        logic [31:0]   low;
        logic [32:0]   high;
        logic [CW-1:0] members;
        logic [CW-1:0] peak_n;
        logic [CW-1:0] ties;
        logic [31:0]   peak_lo;
        logic [32:0]   peak_hi;
        logic          fault;
        logic          done;
    } t_cluster_rec;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [cfp_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [cfp_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [cfp_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                               pready;

    logic          in_valid = 1'b0;
    logic          o_in_ready;
    logic [31:0]   in_value = '0;
    logic          in_last = 1'b0;
    logic          o_out_valid;
    logic          out_ready = 1'b0;
    logic [31:0]   o_cluster_low;
    logic [32:0]   o_cluster_high;
    logic [CW-1:0] o_cluster_members;
    logic [CW-1:0] o_peak_members;
    logic [CW-1:0] o_peak_ties;
    logic [31:0]   o_peak_low;
    logic [32:0]   o_peak_high;
    logic          o_order_fault;
    logic          o_run_done;

    fuzzy_cluster_peak_finder_core #(.COUNT_WIDTH(CW)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_value   (in_value),
        .i_run_end        (in_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_cluster_low    (o_cluster_low),
        .o_cluster_high   (o_cluster_high),
        .o_cluster_members(o_cluster_members),
        .o_peak_members   (o_peak_members),
        .o_peak_ties      (o_peak_ties),
        .o_peak_low       (o_peak_low),
        .o_peak_high      (o_peak_high),
        .o_order_fault    (o_order_fault),
        .o_run_done       (o_run_done)
    );

    always #1 i_clk = ~i_clk;

    // predictor state, mirrors the block's run tracking
    logic [cfp_pkg::FRAC_WIDTH-1:0] fuzz_frac = cfp_pkg::FUZZ_RESET;
    logic [31:0]                    last_value = '0;
    logic [31:0]                    open_lo = '0;
    logic [32:0]                    open_hi = '0;
    logic [CW-1:0]                  open_n = '0;
    logic                           run_open = 1'b0;
    logic [CW-1:0]                  best_n = '0;
    logic [CW-1:0]                  best_ties = '0;
    logic [31:0]                    best_lo = '0;
    logic [32:0]                    best_hi = '0;
    logic                           sticky = 1'b0;

    t_sample      sample_backlog[$];
    t_cluster_rec expected_clusters[$];
    t_pace        pace = PACE_RX_HEAVY;
    logic         in_taken = 1'b0;
    int unsigned  samples_queued = 0;
    int unsigned  samples_taken = 0;
    int unsigned  clusters_checked = 0;
    int unsigned  cluster_faults = 0;
    int unsigned  fuzz_settings = 1;

    function automatic bit skip_cycle(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int unsigned send_idle_pct(input t_pace p);
        return (p == PACE_RX_HEAVY) ? 34 : (p == PACE_TX_HEAVY) ? 58 : 0;
    endfunction

    function automatic int unsigned recv_idle_pct(input t_pace p);
        return (p == PACE_RX_HEAVY) ? 58 : (p == PACE_TX_HEAVY) ? 34 : 0;
    endfunction

    function automatic void show_rec(input string tag, input t_cluster_rec r);
        $display("%s lo=%h hi=%h n=%0d peak=%0d ties=%0d plo=%h phi=%h flt=%b done=%b",
                 tag, r.low, r.high, r.members, r.peak_n, r.ties, r.peak_lo, r.peak_hi,
                 r.fault, r.done);
    endfunction

    task automatic close_cluster(input logic done);
        if (open_n == best_n) begin
            if (best_ties != CNT_MAX)
                best_ties = best_ties + 1'b1;
        end else if (open_n > best_n) begin
            best_n    = open_n;
            best_ties = CW'(1);
            best_lo   = open_lo;
            best_hi   = open_hi;
        end
        expected_clusters.push_back('{open_lo, open_hi, open_n, best_n, best_ties,
                                      best_lo, best_hi, sticky, done});
    endtask

    task automatic fold_sample(input logic [31:0] v, input logic is_last);
        logic [47:0] prod;
        logic [31:0] d;
        logic [31:0] lo;
        logic [32:0] hi;
        if (run_open && v < last_value) begin
            sticky = 1'b1;
        end else begin
            prod = {16'b0, v} * {32'b0, fuzz_frac};
            d    = prod[47:16];
            lo   = v - d;
            hi   = {1'b0, v} + {1'b0, d};
            last_value = v;
            if (run_open && open_hi >= {1'b0, lo}) begin
                open_hi = hi;
                if (open_n != CNT_MAX)
                    open_n = open_n + 1'b1;
            end else begin
                if (run_open)
                    close_cluster(1'b0);
                open_lo  = lo;
                open_hi  = hi;
                open_n   = CW'(1);
                run_open = 1'b1;
            end
        end
        if (is_last) begin
            close_cluster(1'b1);
            last_value = '0;
            open_lo    = '0;
            open_hi    = '0;
            open_n     = '0;
            run_open   = 1'b0;
            best_n     = '0;
            best_ties  = '0;
            best_lo    = '0;
            best_hi    = '0;
            sticky     = 1'b0;
        end
    endtask

    // sender side
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                in_taken = 1'b0;
                if (sample_backlog.size() != 0 && !skip_cycle(send_idle_pct(pace))) begin
                    in_value <= sample_backlog[0].value;
                    in_last  <= sample_backlog[0].is_last;
                    in_valid <= 1'b1;
                    void'(sample_backlog.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= !skip_cycle(recv_idle_pct(pace));
        end
    end

    // transfers on both channels
    always @(posedge i_clk) begin
        t_cluster_rec got;
        t_cluster_rec want;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                fold_sample(in_value, in_last);
                in_taken = 1'b1;
                samples_taken++;
            end
            if (o_out_valid && out_ready) begin
                got = '{o_cluster_low, o_cluster_high, o_cluster_members, o_peak_members,
                        o_peak_ties, o_peak_low, o_peak_high, o_order_fault, o_run_done};
                clusters_checked++;
                if (expected_clusters.size() == 0) begin
                    cluster_faults++;
                    if (cluster_faults <= 10)
                        show_rec("unexpected cluster     ", got);
                end else begin
                    want = expected_clusters.pop_front();
                    if (got !== want) begin
                        cluster_faults++;
                        if (cluster_faults <= 10) begin
                            show_rec("cluster mismatch  exp:", want);
                            show_rec("                  got:", got);
                        end
                    end
                end
            end
        end
    end

    task automatic push_sample(input logic [31:0] v, input logic is_last);
        sample_backlog.push_back('{v, is_last});
        samples_queued++;
    endtask

    // ascending runs with random steps around the interval width, a few out of order
    task automatic queue_random_runs(input int unsigned n, input logic [15:0] frac);
        int unsigned made;
        int unsigned len;
        int unsigned k;
        logic [31:0] v;
        logic [31:0] d;
        logic [47:0] prod;
        logic [33:0] step;
        logic [33:0] nxt;
        made = 0;
        while (made < n) begin
            len = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0:       v = $urandom_range(0, 255);
                1:       v = $urandom;
                2:       v = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                default: v = $urandom_range(0, 1_000_000);
            endcase
            for (k = 0; k < len; k++) begin
                if (k > 0 && v != 0 && $urandom_range(0, 19) == 0) begin
                    push_sample($urandom_range(0, v - 1), k == len - 1);
                end else begin
                    push_sample(v, k == len - 1);
                    prod = {16'b0, v} * {32'b0, frac};
                    d    = prod[47:16];
                    case ($urandom_range(0, 4))
                        0:       step = 0;
                        1:       step = $urandom_range(0, d);
                        2:       step = {2'b0, d} + $urandom_range(0, d);
                        3:       step = $urandom_range(0, 64);
                        default: step = $urandom;
                    endcase
                    nxt = {2'b0, v} + step;
                    v   = (nxt > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
                end
                made++;
            end
        end
    endtask

    task automatic apb_set_fuzz(input logic [cfp_pkg::FRAC_WIDTH-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {cfp_pkg::REG_FUZZ, 2'b00};
        pwdata  <= {{(cfp_pkg::APB_DATA_WIDTH-cfp_pkg::FRAC_WIDTH){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fuzz_frac = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[cfp_pkg::FRAC_WIDTH-1:0] !== val) begin
            cluster_faults++;
            if (cluster_faults <= 10)
                $display("fuzz readback exp=%h got=%h", val,
                         prdata[cfp_pkg::FRAC_WIDTH-1:0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        fuzz_settings++;
    endtask

    task automatic wait_drained;
        while (samples_taken != samples_queued || expected_clusters.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int unsigned k;
        logic [cfp_pkg::FRAC_WIDTH-1:0] mid_frac;
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;

        // default fuzz: single-value runs at both ends of the range
        push_sample(32'd0, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b1);
        // merge, close, dropped value, then close and final together
        push_sample(32'd100, 1'b0);
        push_sample(32'd105, 1'b0);
        push_sample(32'd200, 1'b0);
        push_sample(32'd150, 1'b0);
        push_sample(32'd300, 1'b1);
        // three singles tie, run ends on a dropped value
        push_sample(32'd1000, 1'b0);
        push_sample(32'd5000, 1'b0);
        push_sample(32'd9000, 1'b0);
        push_sample(32'd10, 1'b1);
        // later cluster beats the first
        push_sample(32'd10, 1'b0);
        push_sample(32'd5000, 1'b0);
        push_sample(32'd5001, 1'b0);
        push_sample(32'd5002, 1'b1);
        // two pairs tie, peak stays on the first
        push_sample(32'd1000, 1'b0);
        push_sample(32'd1001, 1'b0);
        push_sample(32'd2000, 1'b0);
        push_sample(32'd2001, 1'b0);
        push_sample(32'd3000, 1'b1);
        // new run may start below the previous run's values
        push_sample(32'd5, 1'b0);
        push_sample(32'hFFFF_FFF0, 1'b1);
        queue_random_runs(240, fuzz_frac);
        wait_drained();

        apb_set_fuzz('1);
        pace = PACE_TX_HEAVY;
        queue_random_runs(240, fuzz_frac);
        wait_drained();

        // zero width: equal values merge, distinct ones stay single and tie
        apb_set_fuzz('0);
        pace = PACE_NONE;
        for (k = 0; k < 6; k++)
            push_sample(32'd7, 1'b0);
        for (k = 0; k < 4; k++)
            push_sample(32'd9, k == 3);
        for (k = 0; k < 12; k++)
            push_sample(k, k == 11);
        queue_random_runs(100, fuzz_frac);
        wait_drained();

        mid_frac = 16'($urandom_range(1, 65534));
        apb_set_fuzz(mid_frac);
        queue_random_runs(170, fuzz_frac);
        wait_drained();

        cluster_faults += expected_clusters.size();
        $display("%0d samples sent over %0d fuzz settings, %0d clusters checked",
                 samples_taken, fuzz_settings, clusters_checked);
        $display("zero-width merge and tie runs included, %0d mismatches", cluster_faults);
        if (cluster_faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #400_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
